### sv/lobm_pkg.sv
// ----------------------------------------------------------------------------
// lobm_pkg
// Types and codes shared by the order book matcher front, engine and top.
// ----------------------------------------------------------------------------
package lobm_pkg;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_CANCEL = 2'd1,
		OP_QLVL   = 2'd2,
		OP_QORD   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK   = 3'd0,
		ST_DUP  = 3'd1,
		ST_NF   = 3'd2,
		ST_FULL = 3'd3,
		ST_OOW  = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] order_id;
		logic        side;
		logic [7:0]  price;
		logic [23:0] quantity;
	} req_t;

	typedef struct packed {
		logic        trade_valid;
		logic [31:0] aggressor_id;
		logic [31:0] maker_id;
		logic [7:0]  fill_price;
		logic [23:0] trade_quantity;
		logic [2:0]  status;
		logic [23:0] rested_quantity;
		logic [29:0] level_quantity;
		logic [7:0]  best_bid_price;
		logic [7:0]  best_ask_price;
		logic [1:0]  top_valid;
		logic        last;
	} rsp_t;

	// classified command handed from front to engine
	typedef struct packed {
		op_t         op;
		logic [31:0] id;
		logic        side;
		logic [7:0]  price;
		logic [23:0] qty;
		logic        price_ok;
	} cmd_t;

	typedef struct packed {
		logic [31:0] rid;
		logic [7:0]  price;
		logic [23:0] qty;
	} trade_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIND,
		S_DISP,
		S_MTOP,
		S_MHD,
		S_MSL,
		S_MREST,
		S_RLV,
		S_CSL,
		S_CLV,
		S_QRD,
		S_SR1,
		S_SR2,
		S_FIN,
		S_ERD,
		S_EWR
	} eng_state_t;

endpackage

### sv/lobm_front.sv
// ----------------------------------------------------------------------------
// lobm_front
// Accepts request beats, masks the id, checks the price window and queues
// the classified command for the engine.
// ----------------------------------------------------------------------------
module lobm_front import lobm_pkg::*; #(
	parameter int PRICE_TICKS = 256,
	parameter int ID_BITS     = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic cmd_valid,
	input  logic cmd_pop,
	output cmd_t cmd
);

	localparam logic [31:0] ID_MASK = (ID_BITS >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << ID_BITS) - 64'd1);

	cmd_t       q_mem [2];
	cmd_t       cmd_d;
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	always_comb begin
		cmd_d.op       = op_t'(req.operation);
		cmd_d.id       = req.order_id & ID_MASK;
		cmd_d.side     = req.side;
		cmd_d.price    = req.price;
		cmd_d.qty      = req.quantity;
		cmd_d.price_ok = (13'(req.price) < 13'(PRICE_TICKS));
	end

	assign req_ready = (cnt_q != 2'd2);
	assign push      = req_valid && req_ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_mem[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wp_q] <= cmd_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (cmd_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end

endmodule

### sv/lobm_engine.sv
// ----------------------------------------------------------------------------
// lobm_engine
// Carries out one command at a time on the slot and level memories, buffers
// the trades, then streams the results once top of book is settled.
// ----------------------------------------------------------------------------
module lobm_engine import lobm_pkg::*; #(
	parameter int ORDER_SLOTS = 64,
	parameter int PRICE_TICKS = 256,
	parameter int ID_BITS     = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_pop,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int SW   = $clog2(ORDER_SLOTS);
	localparam int TW   = $clog2(PRICE_TICKS);
	localparam int LVW  = TW + 1;
	localparam int LVLS = 2 * PRICE_TICKS;
	localparam int IDW  = (ID_BITS < 32) ? ID_BITS : 32;
	localparam int PW   = (TW > 8) ? TW : 8;
	localparam int GRP  = (PRICE_TICKS + 15) / 16;
	localparam int GW   = (GRP > 1) ? $clog2(GRP) : 1;

	eng_state_t state_q, state_d, ret_q;

	cmd_t              cmd_q;
	logic [23:0]       qty_q;
	logic [SW-1:0]     slot_q;
	logic [LVW-1:0]    lv_q;
	logic [SW:0]       n_q, e_idx_q;
	status_t           status_q;
	logic [23:0]       rested_q;
	logic [29:0]       lq_q;
	logic [ORDER_SLOTS-1:0] match_q;

	// slot and level state
	logic [ORDER_SLOTS-1:0] sv_q;
	logic [IDW-1:0]    cam_q [ORDER_SLOTS];
	logic [LVLS-1:0]   occ_q;

	logic [IDW-1:0]    sid_mem  [ORDER_SLOTS];
	logic              sside_mem[ORDER_SLOTS];
	logic [7:0]        sprc_mem [ORDER_SLOTS];
	logic [23:0]       sqty_mem [ORDER_SLOTS];
	logic [SW-1:0]     snxt_mem [ORDER_SLOTS];
	logic [SW-1:0]     sprv_mem [ORDER_SLOTS];
	logic [SW-1:0]     lhd_mem  [LVLS];
	logic [SW-1:0]     ltl_mem  [LVLS];
	logic [29:0]       ltot_mem [LVLS];
	trade_t            tb_mem   [ORDER_SLOTS];

	logic [IDW-1:0]    sid_rd;
	logic              sside_rd;
	logic [7:0]        sprc_rd;
	logic [23:0]       sqty_rd;
	logic [SW-1:0]     snxt_rd, sprv_rd, lhd_rd, ltl_rd;
	logic [29:0]       ltot_rd;
	trade_t            tb_rd;

	// best price tracking
	logic [GW-1:0]     bgrp_q, agrp_q;
	logic              bany_q, aany_q;
	logic [TW-1:0]     bb_q, ba_q;
	logic              bv_q, av_q;

	// memory ports
	logic [SW-1:0]     sra, swa, nwa, pwa;
	logic [LVW-1:0]    lra;
	logic              we_slot, we_qty, we_next, we_prev, we_head, we_tail, we_tot, we_tb;
	logic [23:0]       wd_qty;
	logic [SW-1:0]     wd_next, wd_prev, wd_head, wd_tail;
	logic [29:0]       wd_tot;
	logic              occ_set, occ_clr, sv_set, sv_clr;

	// derived values
	logic              found, free_any;
	logic [SW-1:0]     fslot, free_idx;
	logic [LVW-1:0]    lv_cmd, lv_opp, lv_slot;
	logic [TW-1:0]     bp;
	logic              have_best, crosses, take;
	logic [23:0]       fill, sq_left;
	logic              lvl_empties, hd_hit, tl_hit;
	logic [GRP*16-1:0] bid_pad, ask_pad;
	logic [GRP-1:0]    bsum, asum;
	logic [GW-1:0]     bgrp_d, agrp_d;
	logic [15:0]       bword, aword;
	logic [3:0]        bbit, abit;
	logic              out_free, e_last, load;
	rsp_t              rsp_d;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	// ---------------- lookups ----------------
	always_comb begin
		found = 1'b0;
		fslot = '0;
		for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				found = 1'b1;
				fslot = SW'(i);
			end
		end
		free_any = 1'b0;
		free_idx = '0;
		for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
			if (!sv_q[i]) begin
				free_any = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	always_comb begin
		lv_cmd    = cmd_q.side ? LVW'(PRICE_TICKS) + LVW'(cmd_q.price) : LVW'(cmd_q.price);
		have_best = cmd_q.side ? bv_q : av_q;
		bp        = cmd_q.side ? bb_q : ba_q;
		crosses   = cmd_q.side ? (PW'(cmd_q.price) <= PW'(bp)) :
			(PW'(cmd_q.price) >= PW'(bp));
		take      = (qty_q != 24'd0) && have_best && crosses;
		// a buy hits the ask side, a sell the bid side
		lv_opp    = cmd_q.side ? LVW'(bp) : LVW'(PRICE_TICKS) + LVW'(bp);
		lv_slot   = sside_rd ? LVW'(PRICE_TICKS) + LVW'(sprc_rd) : LVW'(sprc_rd);
		fill      = (qty_q < sqty_rd) ? qty_q : sqty_rd;
		sq_left   = sqty_rd - fill;
		hd_hit    = (lhd_rd == slot_q);
		tl_hit    = (ltl_rd == slot_q);
		lvl_empties = hd_hit && tl_hit;
	end

	// two-step best price search: group summary, then bit within group
	always_comb begin
		bid_pad = '0;
		ask_pad = '0;
		for (int i = 0; i < PRICE_TICKS; i++) begin
			bid_pad[i] = occ_q[i];
			ask_pad[i] = occ_q[PRICE_TICKS + i];
		end
		for (int g = 0; g < GRP; g++) begin
			bsum[g] = |bid_pad[g*16 +: 16];
			asum[g] = |ask_pad[g*16 +: 16];
		end
		bgrp_d = '0;
		for (int g = 0; g < GRP; g++) begin
			if (bsum[g]) begin
				bgrp_d = GW'(g);
			end
		end
		agrp_d = '0;
		for (int g = GRP - 1; g >= 0; g--) begin
			if (asum[g]) begin
				agrp_d = GW'(g);
			end
		end
		bword = bid_pad[{bgrp_q, 4'b0000} +: 16];
		aword = ask_pad[{agrp_q, 4'b0000} +: 16];
		bbit = 4'd0;
		for (int b = 0; b < 16; b++) begin
			if (bword[b]) begin
				bbit = 4'(b);
			end
		end
		abit = 4'd0;
		for (int b = 15; b >= 0; b--) begin
			if (aword[b]) begin
				abit = 4'(b);
			end
		end
	end

	// ---------------- control ----------------
	assign out_free = !rsp_valid_q || rsp_ready;
	assign e_last   = (n_q == '0) || ((e_idx_q + (SW+1)'(1)) == n_q);
	assign load     = (state_q == S_EWR) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		sra     = slot_q;
		lra     = lv_q;
		swa     = free_idx;
		nwa     = slot_q;
		pwa     = slot_q;
		we_slot = 1'b0;
		we_qty  = 1'b0;
		we_next = 1'b0;
		we_prev = 1'b0;
		we_head = 1'b0;
		we_tail = 1'b0;
		we_tot  = 1'b0;
		we_tb   = 1'b0;
		wd_qty  = qty_q;
		wd_next = slot_q;
		wd_prev = slot_q;
		wd_head = slot_q;
		wd_tail = slot_q;
		wd_tot  = ltot_rd;
		occ_set = 1'b0;
		occ_clr = 1'b0;
		sv_set  = 1'b0;
		sv_clr  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					state_d = S_FIND;
				end
			end
			S_FIND: state_d = S_DISP;
			S_DISP: begin
				case (cmd_q.op)
					OP_ADD: begin
						if (found || !cmd_q.price_ok || qty_q == 24'd0) begin
							state_d = S_FIN;
						end else begin
							state_d = S_MTOP;
						end
					end
					OP_CANCEL: begin
						if (found) begin
							sra     = fslot;
							state_d = S_CSL;
						end else begin
							state_d = S_FIN;
						end
					end
					OP_QLVL: begin
						if (cmd_q.price_ok && occ_q[lv_cmd]) begin
							lra     = lv_cmd;
							state_d = S_QRD;
						end else begin
							state_d = S_FIN;
						end
					end
					default: state_d = S_FIN;
				endcase
			end
			S_MTOP: begin
				if (take) begin
					lra     = lv_opp;
					state_d = S_MHD;
				end else begin
					state_d = S_MREST;
				end
			end
			S_MHD: begin
				sra     = lhd_rd;
				state_d = S_MSL;
			end
			S_MSL: begin
				we_tb   = 1'b1;
				we_qty  = 1'b1;
				swa     = slot_q;
				wd_qty  = sq_left;
				we_tot  = 1'b1;
				wd_tot  = ltot_rd - 30'(fill);
				state_d = S_MTOP;
				if (sq_left == 24'd0) begin
					sv_clr = 1'b1;
					if (tl_hit) begin
						occ_clr = 1'b1;
						state_d = S_SR1;
					end else begin
						we_head = 1'b1;
						wd_head = snxt_rd;
					end
				end
			end
			S_MREST: begin
				if (qty_q == 24'd0 || !free_any) begin
					state_d = S_FIN;
				end else begin
					we_slot = 1'b1;
					we_qty  = 1'b1;
					swa     = free_idx;
					sv_set  = 1'b1;
					lra     = cmd_q.side ? LVW'(PRICE_TICKS) + LVW'(cmd_q.price) :
						LVW'(cmd_q.price);
					state_d = S_RLV;
				end
			end
			S_RLV: begin
				we_tail = 1'b1;
				if (!occ_q[lv_q]) begin
					occ_set = 1'b1;
					we_head = 1'b1;
					we_tot  = 1'b1;
					wd_tot  = 30'(qty_q);
					state_d = S_SR1;
				end else begin
					we_prev = 1'b1;
					wd_prev = ltl_rd;
					we_next = 1'b1;
					nwa     = ltl_rd;
					we_tot  = 1'b1;
					wd_tot  = ltot_rd + 30'(qty_q);
					state_d = S_FIN;
				end
			end
			S_CSL: begin
				lra     = lv_slot;
				state_d = S_CLV;
			end
			S_CLV: begin
				sv_clr  = 1'b1;
				we_tot  = 1'b1;
				wd_tot  = ltot_rd - 30'(sqty_rd);
				state_d = S_FIN;
				if (lvl_empties) begin
					occ_clr = 1'b1;
					state_d = S_SR1;
				end else if (hd_hit) begin
					we_head = 1'b1;
					wd_head = snxt_rd;
				end else if (tl_hit) begin
					we_tail = 1'b1;
					wd_tail = sprv_rd;
				end else begin
					// middle of the queue: splice neighbours together
					we_next = 1'b1;
					nwa     = sprv_rd;
					wd_next = snxt_rd;
					we_prev = 1'b1;
					pwa     = snxt_rd;
					wd_prev = sprv_rd;
				end
			end
			S_QRD:  state_d = S_FIN;
			S_SR1:  state_d = S_SR2;
			S_SR2:  state_d = ret_q;
			S_FIN:  state_d = S_ERD;
			S_ERD:  state_d = S_EWR;
			S_EWR: begin
				if (out_free) begin
					state_d = e_last ? S_IDLE : S_ERD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ---------------- working registers ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_q    <= cmd;
					qty_q    <= cmd.qty;
					n_q      <= '0;
					e_idx_q  <= '0;
					status_q <= ST_OK;
					rested_q <= 24'd0;
					lq_q     <= 30'd0;
				end
			end
			S_FIND: begin
				for (int i = 0; i < ORDER_SLOTS; i++) begin
					match_q[i] <= sv_q[i] && (cam_q[i] == cmd_q.id[IDW-1:0]);
				end
			end
			S_DISP: begin
				case (cmd_q.op)
					OP_ADD: begin
						if (found) begin
							status_q <= ST_DUP;
						end else if (!cmd_q.price_ok) begin
							status_q <= ST_OOW;
						end
					end
					OP_CANCEL: begin
						slot_q <= fslot;
						if (!found) begin
							status_q <= ST_NF;
						end
					end
					OP_QLVL: begin
						lv_q <= lv_cmd;
						if (!cmd_q.price_ok) begin
							status_q <= ST_OOW;
						end else if (!occ_q[lv_cmd]) begin
							status_q <= ST_NF;
						end
					end
					default: status_q <= found ? ST_OK : ST_NF;
				endcase
			end
			S_MTOP: begin
				if (take) begin
					lv_q <= lv_opp;
				end
			end
			S_MHD: slot_q <= lhd_rd;
			S_MSL: begin
				qty_q <= qty_q - fill;
				n_q   <= n_q + (SW+1)'(1);
				ret_q <= S_MTOP;
			end
			S_MREST: begin
				if (qty_q != 24'd0) begin
					if (!free_any) begin
						status_q <= ST_FULL;
					end
					slot_q <= free_idx;
					lv_q   <= cmd_q.side ? LVW'(PRICE_TICKS) + LVW'(cmd_q.price) :
						LVW'(cmd_q.price);
				end
			end
			S_RLV: begin
				rested_q <= qty_q;
				ret_q    <= S_FIN;
			end
			S_CSL: lv_q <= lv_slot;
			S_CLV: ret_q <= S_FIN;
			S_QRD: lq_q <= ltot_rd;
			S_SR1: begin
				bgrp_q <= bgrp_d;
				agrp_q <= agrp_d;
				bany_q <= |bsum;
				aany_q <= |asum;
			end
			S_EWR: begin
				if (out_free && !e_last) begin
					e_idx_q <= e_idx_q + (SW+1)'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bb_q <= '0;
			ba_q <= '0;
			bv_q <= 1'b0;
			av_q <= 1'b0;
		end else if (state_q == S_SR2) begin
			bb_q <= TW'({bgrp_q, bbit});
			ba_q <= TW'({agrp_q, abit});
			bv_q <= bany_q;
			av_q <= aany_q;
		end
	end

	// ---------------- valid and occupancy flags ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_q  <= '0;
			occ_q <= '0;
		end else begin
			if (sv_set) begin
				sv_q[free_idx] <= 1'b1;
			end
			if (sv_clr) begin
				sv_q[slot_q] <= 1'b0;
			end
			if (occ_set) begin
				occ_q[lv_q] <= 1'b1;
			end
			if (occ_clr) begin
				occ_q[lv_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sv_set) begin
			cam_q[free_idx] <= cmd_q.id[IDW-1:0];
		end
	end

	// ---------------- memories ----------------
	always_ff @(posedge clk) begin
		if (we_slot) begin
			sid_mem[swa]   <= cmd_q.id[IDW-1:0];
			sside_mem[swa] <= cmd_q.side;
			sprc_mem[swa]  <= cmd_q.price;
		end
		if (we_qty) begin
			sqty_mem[swa] <= wd_qty;
		end
		if (we_next) begin
			snxt_mem[nwa] <= wd_next;
		end
		if (we_prev) begin
			sprv_mem[pwa] <= wd_prev;
		end
		sid_rd   <= sid_mem[sra];
		sside_rd <= sside_mem[sra];
		sprc_rd  <= sprc_mem[sra];
		sqty_rd  <= sqty_mem[sra];
		snxt_rd  <= snxt_mem[sra];
		sprv_rd  <= sprv_mem[sra];
	end

	always_ff @(posedge clk) begin
		if (we_head) begin
			lhd_mem[lv_q] <= wd_head;
		end
		if (we_tail) begin
			ltl_mem[lv_q] <= wd_tail;
		end
		if (we_tot) begin
			ltot_mem[lv_q] <= wd_tot;
		end
		lhd_rd  <= lhd_mem[lra];
		ltl_rd  <= ltl_mem[lra];
		ltot_rd <= ltot_mem[lra];
	end

	always_ff @(posedge clk) begin
		if (we_tb) begin
			tb_mem[n_q[SW-1:0]] <= '{rid: 32'(sid_rd), price: sprc_rd, qty: fill};
		end
		tb_rd <= tb_mem[e_idx_q[SW-1:0]];
	end

	// ---------------- result register ----------------
	always_comb begin
		rsp_d.trade_valid     = (n_q != '0);
		rsp_d.aggressor_id    = (n_q != '0) ? cmd_q.id : 32'd0;
		rsp_d.maker_id        = (n_q != '0) ? tb_rd.rid : 32'd0;
		rsp_d.fill_price      = (n_q != '0) ? tb_rd.price : 8'd0;
		rsp_d.trade_quantity  = (n_q != '0) ? tb_rd.qty : 24'd0;
		rsp_d.status          = e_last ? status_q : ST_OK;
		rsp_d.rested_quantity = e_last ? rested_q : 24'd0;
		rsp_d.level_quantity  = e_last ? lq_q : 30'd0;
		rsp_d.best_bid_price  = bv_q ? 8'(bb_q) : 8'd0;
		rsp_d.best_ask_price  = av_q ? 8'(ba_q) : 8'd0;
		rsp_d.top_valid       = {av_q, bv_q};
		rsp_d.last            = e_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### sv/limit_order_book_matcher_core.sv
// Flow: the engine takes a command, looks up its id, dispatches it, then streams the
// results; each fill runs S_MTOP, S_MHD and S_MSL, and S_SR1 and S_SR2 (best price
// search) when it empties the best level. The engine handles one item at a time.
// The 2-deep command queue accepts until full while engine or result port stalls.
// Reset: async active low clears the valid and occupancy flags, best prices and
// handshake state; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
// limit_order_book_matcher_core
// Price-time priority order book: request front, command queue, book engine.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_core import lobm_pkg::*; #(
	parameter int ORDER_SLOTS = 64,
	parameter int PRICE_TICKS = 256,
	parameter int ID_BITS     = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic cmd_valid, cmd_pop;
	cmd_t cmd;

	lobm_front #(
		.PRICE_TICKS (PRICE_TICKS),
		.ID_BITS     (ID_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	lobm_engine #(
		.ORDER_SLOTS (ORDER_SLOTS),
		.PRICE_TICKS (PRICE_TICKS),
		.ID_BITS     (ID_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
